// ----- src/pppi_pkg.sv -----
package pppi_pkg;

  // Stall detection window.
  localparam int unsigned WINDOW_LEN = 8;
  localparam int unsigned SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned DELTA_W    = 25;
  localparam int unsigned SUM_W      = DELTA_W + SLOT_W;

  // Loop constants in fixed point: pressure Q.8, drive Q15, integrator Q18.
  localparam int unsigned DEADBAND   = 128;
  localparam int unsigned I_MAX      = 262144;
  localparam int unsigned FULL_DRIVE = 32768;
  localparam int unsigned MIN_DRIVE  = 9830;
  localparam int unsigned EXIT_MS    = 500;
  localparam int unsigned FAIL_MS    = 5000;

  // Integrator step: round(x * 1024 / 1000) = floor((128 x + 62) / 125).
  // Any |x| from X_SAT upwards gives a step that saturates the integrator.
  localparam int unsigned X_SAT      = 512000;
  localparam int unsigned STEP_SAT   = 524288;
  localparam int unsigned ROUND125   = 62;
  localparam int unsigned RECIP125   = 68719477;
  localparam int unsigned SHIFT125   = 33;

  // Division by five through a reciprocal, exact below 2^18.
  localparam int unsigned RECIP5     = 209716;
  localparam int unsigned SHIFT5     = 20;

  // Feed limit: round(m * 96 / 5), full drive from M_SAT upwards.
  localparam int unsigned M_SAT      = 1707;
  localparam int unsigned FEED_GAIN  = 96;
  localparam int unsigned FEED_ROUND = 2;

  // PI output: |num| thresholds for minimum drive and for full drive.
  localparam int unsigned RUN_MIN    = 786440;
  localparam int unsigned Q_SAT      = 2621400;
  localparam int unsigned ROUND80    = 40;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_TARGET = 2'd1,
    MODE_FEED   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_STOP = 2'd0,
    ACT_CW   = 2'd1,
    ACT_CCW  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_TARGET   = 3'd1,
    CFG_DURATION = 3'd2,
    CFG_UPPER    = 3'd3,
    CFG_LOWER    = 3'd4,
    CFG_LEVEL    = 3'd5,
    CFG_VACUUM   = 3'd6
  } cfg_idx_t;

endpackage

// ----- src/pump_pressure_pi_controller.sv -----
// Pump pressure PI controller. Each input item is one control tick; each
// tick gives exactly one result item (motor action, drive level in Q15, done
// and failure flags). The block takes one item per clock cycle while
// in_stall is low. Three stages in front prepare the state-free arithmetic
// (error, deadband, the error-time product and the constant divisions),
// the fourth stage holds the whole control state and updates it with each
// item, so consecutive ticks see each other's state without a bubble. Two
// stages behind it finish the drive division. An output register with a
// skid stage decouples the sides: in_stall rises only once both hold an
// item, and the whole pipeline then waits. Configuration registers are
// written through the cfg port, which is always ready; they must only be
// changed while no item is in flight.
module pump_pressure_pi_controller (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] measured_pressure,
  input  logic [15:0]        tick_ms,
  input  logic               first_run,
  input  logic               settings_changed,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         motor_action,
  output logic [15:0]        drive_level,
  output logic               done_res,
  output logic               failure,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [1:0]         mode;
  logic signed [23:0] target_pressure;
  logic [23:0]        feed_duration_ms;
  logic signed [23:0] upper_limit;
  logic signed [23:0] lower_limit;
  logic [15:0]        feed_level;
  logic               vacuum_direction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= '0;
      target_pressure  <= '0;
      feed_duration_ms <= '0;
      upper_limit      <= '0;
      lower_limit      <= '0;
      feed_level       <= '0;
      vacuum_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pppi_pkg::CFG_MODE:     mode             <= cfg_data[1:0];
        pppi_pkg::CFG_TARGET:   target_pressure  <= cfg_data;
        pppi_pkg::CFG_DURATION: feed_duration_ms <= cfg_data;
        pppi_pkg::CFG_UPPER:    upper_limit      <= cfg_data;
        pppi_pkg::CFG_LOWER:    lower_limit      <= cfg_data;
        pppi_pkg::CFG_LEVEL:    feed_level       <= cfg_data[15:0];
        pppi_pkg::CFG_VACUUM:   vacuum_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it halts only while the skid stage
  // holds an item that the output side has not yet taken.
  logic skid_valid;
  logic adv;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  // ---------------------------------------------------------------------
  // Stage 1: input register.
  // ---------------------------------------------------------------------
  logic               s1_valid;
  logic signed [23:0] s1_p;
  logic [15:0]        s1_tick;
  logic               s1_first;
  logic               s1_changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p       <= measured_pressure;
      s1_tick    <= tick_ms;
      s1_first   <= first_run;
      s1_changed <= settings_changed;
    end
  end

  // Error with deadband, its magnitude times the tick, and the distance to
  // the nearer edge of the feed pressure window.
  logic signed [24:0] e1;
  logic [24:0]        e1_abs;
  logic [23:0]        mag1;
  logic               db1;
  logic signed [24:0] e_eff1;
  logic [23:0]        mag_eff1;
  logic [39:0]        x1;
  logic signed [24:0] up_d1;
  logic signed [24:0] lo_d1;
  logic               in_win1;
  logic [23:0]        m1;

  always_comb begin
    e1       = 25'(target_pressure) - 25'(s1_p);
    e1_abs   = e1[24] ? 25'(-e1) : 25'(e1);
    mag1     = e1_abs[23:0];
    db1      = mag1 < 24'(pppi_pkg::DEADBAND);
    e_eff1   = db1 ? '0 : e1;
    mag_eff1 = db1 ? '0 : mag1;
    x1       = 40'(mag_eff1) * 40'(s1_tick);
    up_d1    = 25'(upper_limit) - 25'(s1_p);
    lo_d1    = 25'(s1_p) - 25'(lower_limit);
    in_win1  = !up_d1[24] && !lo_d1[24];
    m1       = (up_d1 < lo_d1) ? up_d1[23:0] : lo_d1[23:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2.
  // ---------------------------------------------------------------------
  logic               s2_valid;
  logic signed [24:0] s2_e;
  logic [23:0]        s2_mag;
  logic               s2_db;
  logic               s2_neg;
  logic [39:0]        s2_x;
  logic [15:0]        s2_tick;
  logic               s2_first;
  logic               s2_changed;
  logic               s2_in_win;
  logic [23:0]        s2_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_e       <= e_eff1;
      s2_mag     <= mag_eff1;
      s2_db      <= db1;
      s2_neg     <= e1[24] && !db1;
      s2_x       <= x1;
      s2_tick    <= s1_tick;
      s2_first   <= s1_first;
      s2_changed <= s1_changed;
      s2_in_win  <= in_win1;
      s2_m       <= m1;
    end
  end

  // Both constant divisions, as reciprocal products on saturated operands.
  logic        isat2;
  logic [25:0] n2;
  logic [52:0] prod_i2;
  logic        msat2;
  logic [17:0] mn2;
  logic [35:0] prod_m2;

  always_comb begin
    isat2   = s2_x >= 40'(pppi_pkg::X_SAT);
    n2      = {s2_x[18:0], 7'd0} + 26'(pppi_pkg::ROUND125);
    prod_i2 = 53'(n2) * 53'(pppi_pkg::RECIP125);
    msat2   = s2_m >= 24'(pppi_pkg::M_SAT);
    mn2     = 18'(s2_m[10:0]) * 18'(pppi_pkg::FEED_GAIN) + 18'(pppi_pkg::FEED_ROUND);
    prod_m2 = 36'(mn2) * 36'(pppi_pkg::RECIP5);
  end

  // ---------------------------------------------------------------------
  // Stage 3: feeds the state update.
  // ---------------------------------------------------------------------
  logic               s3_valid;
  logic signed [24:0] s3_e;
  logic [23:0]        s3_mag;
  logic               s3_db;
  logic               s3_neg;
  logic [15:0]        s3_tick;
  logic               s3_first;
  logic               s3_changed;
  logic               s3_isat;
  logic [52:0]        s3_prod_i;
  logic               s3_in_win;
  logic               s3_msat;
  logic [35:0]        s3_prod_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_e       <= s2_e;
      s3_mag     <= s2_mag;
      s3_db      <= s2_db;
      s3_neg     <= s2_neg;
      s3_tick    <= s2_tick;
      s3_first   <= s2_first;
      s3_changed <= s2_changed;
      s3_isat    <= isat2;
      s3_prod_i  <= prod_i2;
      s3_in_win  <= s2_in_win;
      s3_msat    <= msat2;
      s3_prod_m  <= prod_m2;
    end
  end

  // ---------------------------------------------------------------------
  // Control state, updated once per item.
  // ---------------------------------------------------------------------
  logic signed [19:0]                   integrator;
  logic [23:0]                          prev_error_mag;
  logic [15:0]                          stall_time_ms;
  logic [15:0]                          recover_time_ms;
  logic                                 stall_flag;
  logic signed [pppi_pkg::DELTA_W-1:0]  delta_window [pppi_pkg::WINDOW_LEN];
  logic signed [pppi_pkg::SUM_W-1:0]    window_sum;
  logic [pppi_pkg::SLOT_W-1:0]          window_slot;
  logic [23:0]                          feed_elapsed_ms;

  logic signed [19:0]                   integrator_next;
  logic [23:0]                          prev_error_mag_next;
  logic [15:0]                          stall_time_ms_next;
  logic [15:0]                          recover_time_ms_next;
  logic                                 stall_flag_next;
  logic signed [pppi_pkg::SUM_W-1:0]    window_sum_next;
  logic [pppi_pkg::SLOT_W-1:0]          window_slot_next;
  logic [23:0]                          feed_elapsed_ms_next;
  logic                                 win_clr;
  logic                                 win_wr;

  // Arithmetic of the state stage.
  logic [19:0]                          step_mag;
  logic signed [20:0]                   step;
  logic signed [20:0]                   acc;
  logic signed [19:0]                   base;
  logic signed [19:0]                   integ_new;
  logic signed [36:0]                   num;
  logic [35:0]                          anum;
  logic                                 run;
  logic [21:0]                          a_rnd;
  logic signed [pppi_pkg::DELTA_W-1:0]  delta;
  logic signed [pppi_pkg::SUM_W-1:0]    sum_new;
  logic                                 falling;
  logic [15:0]                          st_base;
  logic [16:0]                          st_sum;
  logic [16:0]                          rt_sum;
  logic [23:0]                          el;
  logic [24:0]                          el_sum;
  logic [15:0]                          lim;
  logic [15:0]                          drive;

  // Candidate result of the state stage.
  pppi_pkg::action_t                    act3;
  logic                                 done3;
  logic                                 fail3;
  logic                                 sel_tgt3;
  logic [15:0]                          lvl_feed3;

  always_comb begin
    // Integrator update with clamping to plus or minus one.
    base     = s3_first ? '0 : integrator;
    step_mag = s3_isat ? 20'(pppi_pkg::STEP_SAT)
                       : s3_prod_i[pppi_pkg::SHIFT125 +: 20];
    step     = s3_neg ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    acc      = 21'(base) + step;
    if (acc > $signed(21'(pppi_pkg::I_MAX))) begin
      integ_new = 20'(pppi_pkg::I_MAX);
    end else if (acc < -$signed(21'(pppi_pkg::I_MAX))) begin
      integ_new = -$signed(20'(pppi_pkg::I_MAX));
    end else begin
      integ_new = acc[19:0];
    end

    // PI numerator: 1536 e + 5 i, so that drive = num / 80 in Q15.
    num   = (37'(s3_e) <<< 10) + (37'(s3_e) <<< 9)
          + (37'(integ_new) <<< 2) + 37'(integ_new);
    anum  = num[36] ? 36'(-num) : 36'(num);
    run   = anum >= 36'(pppi_pkg::RUN_MIN);
    a_rnd = anum[21:0] + 22'(pppi_pkg::ROUND80);

    // Window of error-magnitude changes.
    delta   = $signed({1'b0, s3_mag}) - $signed({1'b0, prev_error_mag});
    sum_new = window_sum - pppi_pkg::SUM_W'(delta_window[window_slot])
            + pppi_pkg::SUM_W'(delta);
    falling = sum_new[pppi_pkg::SUM_W-1];
    st_base = stall_flag ? stall_time_ms : '0;
    st_sum  = 17'(st_base) + 17'(s3_tick);
    rt_sum  = 17'(recover_time_ms) + 17'(s3_tick);

    // Feed timing and pressure window limit.
    el     = (s3_first || s3_changed) ? '0 : feed_elapsed_ms;
    el_sum = 25'(el) + 25'(s3_tick);
    if (!s3_in_win) begin
      lim = '0;
    end else if (s3_msat) begin
      lim = 16'(pppi_pkg::FULL_DRIVE);
    end else begin
      lim = s3_prod_m[pppi_pkg::SHIFT5 +: 16];
    end
    drive = (feed_level > lim) ? lim : feed_level;

    integrator_next      = integrator;
    prev_error_mag_next  = prev_error_mag;
    stall_time_ms_next   = stall_time_ms;
    recover_time_ms_next = recover_time_ms;
    stall_flag_next      = stall_flag;
    window_sum_next      = window_sum;
    window_slot_next     = window_slot;
    feed_elapsed_ms_next = feed_elapsed_ms;
    win_clr              = 1'b0;
    win_wr               = 1'b0;

    act3      = pppi_pkg::ACT_STOP;
    done3     = 1'b0;
    fail3     = 1'b0;
    sel_tgt3  = 1'b0;
    lvl_feed3 = '0;

    case (mode)
      pppi_pkg::MODE_NONE: begin
        done3 = 1'b1;
      end
      pppi_pkg::MODE_TARGET: begin
        done3               = s3_db;
        sel_tgt3            = 1'b1;
        integrator_next     = integ_new;
        prev_error_mag_next = s3_mag;
        if (run) begin
          act3 = num[36] ? pppi_pkg::ACT_CW : pppi_pkg::ACT_CCW;
        end
        if (!s3_first && run) begin
          win_wr          = 1'b1;
          window_sum_next = sum_new;
          window_slot_next = (32'(window_slot) == pppi_pkg::WINDOW_LEN - 1) ? '0
                           : window_slot + 1'b1;
          if (falling) begin
            // While stalled, a falling error counts towards leaving the
            // stalled condition.
            if (stall_flag) begin
              recover_time_ms_next = rt_sum[16] ? '1 : rt_sum[15:0];
              if (recover_time_ms_next > 16'(pppi_pkg::EXIT_MS)) begin
                stall_flag_next = 1'b0;
              end
            end
          end else begin
            // Entering or staying in the stalled condition.
            stall_flag_next      = 1'b1;
            recover_time_ms_next = '0;
            stall_time_ms_next   = st_sum[16] ? '1 : st_sum[15:0];
            fail3 = stall_time_ms_next > 16'(pppi_pkg::FAIL_MS);
          end
        end else begin
          stall_flag_next      = 1'b1;
          stall_time_ms_next   = '0;
          recover_time_ms_next = '0;
          if (s3_first) begin
            win_clr          = 1'b1;
            window_sum_next  = '0;
            window_slot_next = '0;
          end
        end
      end
      pppi_pkg::MODE_FEED: begin
        if (el >= feed_duration_ms) begin
          done3                = 1'b1;
          feed_elapsed_ms_next = el;
        end else begin
          feed_elapsed_ms_next = el_sum[24] ? '1 : el_sum[23:0];
          if (drive > 16'(pppi_pkg::MIN_DRIVE)) begin
            act3      = vacuum_direction ? pppi_pkg::ACT_CW : pppi_pkg::ACT_CCW;
            lvl_feed3 = drive;
          end
        end
      end
      default: ;
    endcase
  end

  logic st_en;
  assign st_en = adv && s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator      <= '0;
      prev_error_mag  <= '0;
      stall_time_ms   <= '0;
      recover_time_ms <= '0;
      stall_flag      <= 1'b0;
      window_sum      <= '0;
      window_slot     <= '0;
      feed_elapsed_ms <= '0;
    end else if (st_en) begin
      integrator      <= integrator_next;
      prev_error_mag  <= prev_error_mag_next;
      stall_time_ms   <= stall_time_ms_next;
      recover_time_ms <= recover_time_ms_next;
      stall_flag      <= stall_flag_next;
      window_sum      <= window_sum_next;
      window_slot     <= window_slot_next;
      feed_elapsed_ms <= feed_elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (st_en && win_clr)) begin
      for (int i = 0; i < pppi_pkg::WINDOW_LEN; i++) begin
        delta_window[i] <= '0;
      end
    end else if (st_en && win_wr) begin
      delta_window[window_slot] <= delta;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: result of the state stage.
  // ---------------------------------------------------------------------
  logic              s4_valid;
  pppi_pkg::action_t s4_action;
  logic              s4_done;
  logic              s4_fail;
  logic              s4_sel_tgt;
  logic [15:0]       s4_lvl_feed;
  logic              s4_qsat;
  logic [17:0]       s4_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_action   <= act3;
      s4_done     <= done3;
      s4_fail     <= fail3;
      s4_sel_tgt  <= sel_tgt3;
      s4_lvl_feed <= lvl_feed3;
      s4_qsat     <= anum >= 36'(pppi_pkg::Q_SAT);
      s4_v        <= a_rnd[21:4];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: drive divided by five (the division by 16 is the shift above).
  // ---------------------------------------------------------------------
  logic              s5_valid;
  pppi_pkg::action_t s5_action;
  logic              s5_done;
  logic              s5_fail;
  logic              s5_sel_tgt;
  logic [15:0]       s5_lvl_feed;
  logic              s5_qsat;
  logic [35:0]       s5_prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_action   <= s4_action;
      s5_done     <= s4_done;
      s5_fail     <= s4_fail;
      s5_sel_tgt  <= s4_sel_tgt;
      s5_lvl_feed <= s4_lvl_feed;
      s5_qsat     <= s4_qsat;
      s5_prod_q   <= 36'(s4_v) * 36'(pppi_pkg::RECIP5);
    end
  end

  logic [15:0] res_level;

  always_comb begin
    if (s5_action == pppi_pkg::ACT_STOP) begin
      res_level = '0;
    end else if (!s5_sel_tgt) begin
      res_level = s5_lvl_feed;
    end else if (s5_qsat) begin
      res_level = 16'(pppi_pkg::FULL_DRIVE);
    end else begin
      res_level = s5_prod_q[pppi_pkg::SHIFT5 +: 16];
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid stage.
  // ---------------------------------------------------------------------
  pppi_pkg::action_t out_action;
  logic [15:0]       out_level;
  logic              out_done;
  logic              out_fail;
  pppi_pkg::action_t skid_action;
  logic [15:0]       skid_level;
  logic              skid_done;
  logic              skid_fail;
  logic              new_res;

  assign new_res = adv && s5_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= new_res;
      end
    end else if (!out_valid) begin
      out_valid <= new_res;
    end else if (new_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((out_valid && !out_stall && skid_valid)) begin
      out_action <= skid_action;
      out_level  <= skid_level;
      out_done   <= skid_done;
      out_fail   <= skid_fail;
    end else if (new_res && (!out_valid || !out_stall)) begin
      out_action <= s5_action;
      out_level  <= res_level;
      out_done   <= s5_done;
      out_fail   <= s5_fail;
    end
    if (new_res && out_valid && out_stall) begin
      skid_action <= s5_action;
      skid_level  <= res_level;
      skid_done   <= s5_done;
      skid_fail   <= s5_fail;
    end
  end

  assign motor_action = out_action;
  assign drive_level  = out_level;
  assign done_res     = out_done;
  assign failure      = out_fail;

endmodule

// ----- src/pppi_checker.sv -----
module pppi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  motor_action,
  input logic [15:0] drive_level,
  input logic        done_res,
  input logic        failure
);

  // A result held back by the receiver stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_action)
      && $stable(drive_level) && $stable(done_res) && $stable(failure))
    else $error("stalled result changed");

  // A stopped motor carries no drive.
  a_stop_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_action == pppi_pkg::ACT_STOP |-> drive_level == 16'd0)
    else $error("drive level without motor action");

  // A running motor is driven above the minimum and at most at full drive.
  a_run_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_action != pppi_pkg::ACT_STOP
      |-> drive_level > 16'(pppi_pkg::MIN_DRIVE)
       && drive_level <= 16'(pppi_pkg::FULL_DRIVE))
    else $error("drive level out of range");

  // Failure is only reported while the loop drives the motor.
  a_fail_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && failure |-> motor_action != pppi_pkg::ACT_STOP)
    else $error("failure reported with motor stopped");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pump_pressure_pi_controller pppi_checker u_pppi_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .motor_action (motor_action),
  .drive_level  (drive_level),
  .done_res     (done_res),
  .failure      (failure)
);
